@@ sv/fla_pkg.sv @@
// ----------------------------------------------------------------------------
// fla_pkg
// shared types and constants of the free list fit allocator
// ----------------------------------------------------------------------------
package fla_pkg;

   localparam int ID_BITS        = 16;
   localparam int STATUS_BITS    = 3;
   localparam int CSR_IDX_BITS   = 2;
   localparam int DEFAULT_MEMORY = 1024;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK         = 3'd0,
      ST_NO_TOTAL   = 3'd1,
      ST_NO_FIT     = 3'd2,
      ST_UNKNOWN_ID = 3'd3,
      ST_FULL       = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FIT_BEST  = 2'd0,
      FIT_WORST = 2'd1,
      FIT_FIRST = 2'd2,
      FIT_POW2  = 2'd3
   } fit_type;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FIT_MODE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MEM_SIZE = 2'd1;

   typedef enum logic [1:0] {
      SH_NONE   = 2'd0,
      SH_REMOVE = 2'd1,
      SH_INSERT = 2'd2,
      SH_INIT   = 2'd3
   } shift_op_type;

   typedef struct packed {
      shift_op_type op;
      logic         wr_en;
   } ft_ctl_type;

endpackage

@@ sv/fla_channels.sv @@
// ----------------------------------------------------------------------------
// fla channels
// request, response and register write channels of the allocator
// ----------------------------------------------------------------------------
interface fla_req_if import fla_pkg::*; #(parameter int ADDR_BITS = 16) ();
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [ADDR_BITS-1:0] req_size;
   logic [ID_BITS-1:0]   target_id;
   modport source (output valid, action, req_size, target_id, input ready);
   modport sink (input valid, action, req_size, target_id, output ready);
endinterface

interface fla_rsp_if import fla_pkg::*; #(parameter int ADDR_BITS = 16) ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [ADDR_BITS-1:0]   extent_addr;
   logic [ADDR_BITS:0]     granted_size;
   logic [ID_BITS-1:0]     assigned_id;
   modport source (output valid, status, extent_addr, granted_size, assigned_id,
                   input ready);
   modport sink (input valid, status, extent_addr, granted_size, assigned_id,
                 output ready);
endinterface

interface fla_csr_if import fla_pkg::*; #(parameter int ADDR_BITS = 16) ();
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [ADDR_BITS-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ sv/free_list_fit_allocator_unit.sv @@
// the response to a request word waits on the grant table scan, the power of two rounding
// shift and the free table scan, each stepped one entry or bit per cycle by the sequencer
// throughput: one request word at a time; the next word is taken once the previous result is
// queued, later while an earlier response still waits in the output register
// reset: synchronous, fit mode best fit, 1024 units in one free extent, no grants
// ----------------------------------------------------------------------------
// free_list_fit_allocator_unit
// extent allocator with first, best, worst and power of two best fit
// ----------------------------------------------------------------------------
module free_list_fit_allocator_unit import fla_pkg::*; #(
   parameter int FREE_ENTRIES  = 16,
   parameter int GRANT_ENTRIES = 16,
   parameter int ADDR_BITS     = 16
) (
   input  logic  clock,
   input  logic  reset,
   fla_req_if.sink   req_chan,
   fla_rsp_if.source rsp_chan,
   fla_csr_if.sink   csr_chan
);

   localparam int AW  = ADDR_BITS;
   localparam int LW  = ADDR_BITS + 1;
   localparam int EW  = ADDR_BITS + 2;
   localparam int FIW = $clog2(FREE_ENTRIES);
   localparam int FCW = $clog2(FREE_ENTRIES + 1);
   localparam int GIW = (GRANT_ENTRIES > 1) ? $clog2(GRANT_ENTRIES) : 1;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_GSCAN   = 8'b0000_0010,
      S_ROUND   = 8'b0000_0100,
      S_FSCAN   = 8'b0000_1000,
      S_ACOMMIT = 8'b0001_0000,
      S_PSCAN   = 8'b0010_0000,
      S_FCOMMIT = 8'b0100_0000,
      S_DONE    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]         fit_mode_ff, fit_mode_in;
   logic [AW-1:0]      mem_size_ff, mem_size_in;
   logic [LW-1:0]      total_ff, total_in;
   logic [ID_BITS-1:0] next_id_ff, next_id_in;

   logic               gv_ff [GRANT_ENTRIES];
   logic               gv_in [GRANT_ENTRIES];
   logic [ID_BITS-1:0] gid_ff [GRANT_ENTRIES];
   logic [AW-1:0]      gs_ff  [GRANT_ENTRIES];
   logic [LW-1:0]      gl_ff  [GRANT_ENTRIES];
   logic               g_wr;

   logic               act_ff, act_in;
   logic [LW-1:0]      size_ff, size_in;
   logic [ID_BITS-1:0] tid_ff, tid_in;
   logic [GIW-1:0]     gidx_ff, gidx_in;
   logic [GIW-1:0]     slot_ff, slot_in;
   logic [LW-1:0]      pow_ff, pow_in;
   logic [FCW-1:0]     fidx_ff, fidx_in;
   logic               found_ff, found_in;
   logic [FIW-1:0]     chosen_ff, chosen_in;
   logic [LW-1:0]      best_len_ff, best_len_in;
   logic [AW-1:0]      best_start_ff, best_start_in;
   logic [EW-1:0]      prev_end_ff, prev_end_in;
   logic [LW-1:0]      prev_len_ff, prev_len_in;
   logic [LW-1:0]      next_len_ff, next_len_in;
   logic [FCW-1:0]     pos_ff, pos_in;
   logic               jprev_ff, jprev_in;
   logic               jnext_ff, jnext_in;

   status_type         res_status_ff, res_status_in;
   logic [AW-1:0]      res_start_ff, res_start_in;
   logic [LW-1:0]      res_size_ff, res_size_in;
   logic [ID_BITS-1:0] res_id_ff, res_id_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [AW-1:0]      rsp_start_ff, rsp_start_in;
   logic [LW-1:0]      rsp_size_ff, rsp_size_in;
   logic [ID_BITS-1:0] rsp_id_ff, rsp_id_in;

   ft_ctl_type         ft_ctl;
   logic [FIW-1:0]     ft_sh_idx, ft_wr_idx;
   logic [AW-1:0]      ft_wr_start;
   logic [LW-1:0]      ft_wr_len;
   logic [AW-1:0]      ft_init_len;
   logic [AW-1:0]      ft_rd_start;
   logic [LW-1:0]      ft_rd_len;
   logic [FCW-1:0]     ft_count;

   logic               req_take, csr_take, better;

   fla_free_table #(
      .FREE_ENTRIES (FREE_ENTRIES),
      .ADDR_BITS    (ADDR_BITS)
   ) u_free_table (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ft_ctl),
      .sh_idx   (ft_sh_idx),
      .wr_idx   (ft_wr_idx),
      .wr_start (ft_wr_start),
      .wr_len   (ft_wr_len),
      .init_len (ft_init_len),
      .rd_idx   (fidx_ff[FIW-1:0]),
      .rd_start (ft_rd_start),
      .rd_len   (ft_rd_len),
      .count    (ft_count)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_take       = csr_chan.valid && csr_chan.ready;

   // shared compare for the fit choice
   assign better = (fit_mode_ff == FIT_WORST) ? (ft_rd_len > best_len_ff)
                                              : (ft_rd_len < best_len_ff);

   always_comb begin
      state_in      = state_ff;
      fit_mode_in   = fit_mode_ff;
      mem_size_in   = mem_size_ff;
      total_in      = total_ff;
      next_id_in    = next_id_ff;
      for (int k = 0; k < GRANT_ENTRIES; k++) gv_in[k] = gv_ff[k];
      g_wr          = 1'b0;
      act_in        = act_ff;
      size_in       = size_ff;
      tid_in        = tid_ff;
      gidx_in       = gidx_ff;
      slot_in       = slot_ff;
      pow_in        = pow_ff;
      fidx_in       = fidx_ff;
      found_in      = found_ff;
      chosen_in     = chosen_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      prev_end_in   = prev_end_ff;
      prev_len_in   = prev_len_ff;
      next_len_in   = next_len_ff;
      pos_in        = pos_ff;
      jprev_in      = jprev_ff;
      jnext_in      = jnext_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_size_in   = res_size_ff;
      res_id_in     = res_id_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_id_in     = rsp_id_ff;
      ft_ctl        = '{op: SH_NONE, wr_en: 1'b0};
      ft_sh_idx     = '0;
      ft_wr_idx     = '0;
      ft_wr_start   = '0;
      ft_wr_len     = '0;
      ft_init_len   = csr_chan.data;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               act_in  = req_chan.action;
               size_in = LW'(req_chan.req_size);
               tid_in  = req_chan.target_id;
               gidx_in = '0;
               if (!req_chan.action && LW'(req_chan.req_size) > total_ff) begin
                  res_status_in = ST_NO_TOTAL;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_GSCAN;
               end
            end
         end
         S_GSCAN: begin
            fidx_in     = '0;
            found_in    = 1'b0;
            prev_end_in = '0;
            pow_in      = LW'(1);
            if (!act_ff && !gv_ff[gidx_ff]) begin
               slot_in = gidx_ff;
               if (size_ff == '0) begin
                  res_status_in = ST_NO_FIT;
                  state_in      = S_DONE;
               end else if (fit_mode_ff == FIT_POW2) begin
                  state_in = S_ROUND;
               end else begin
                  state_in = S_FSCAN;
               end
            end else if (act_ff && gv_ff[gidx_ff] && gid_ff[gidx_ff] == tid_ff) begin
               slot_in       = gidx_ff;
               best_start_in = gs_ff[gidx_ff];
               best_len_in   = gl_ff[gidx_ff];
               state_in      = S_PSCAN;
            end else if (gidx_ff == GIW'(GRANT_ENTRIES - 1)) begin
               res_status_in = act_ff ? ST_UNKNOWN_ID : ST_FULL;
               state_in      = S_DONE;
            end else begin
               gidx_in = gidx_ff + GIW'(1);
            end
         end
         S_ROUND: begin
            if (pow_ff < size_ff) begin
               pow_in = pow_ff << 1;
            end else begin
               size_in  = pow_ff;
               state_in = S_FSCAN;
            end
         end
         S_FSCAN: begin
            if (fidx_ff >= ft_count) begin
               if (found_ff) begin
                  state_in = S_ACOMMIT;
               end else begin
                  res_status_in = ST_NO_FIT;
                  state_in      = S_DONE;
               end
            end else begin
               fidx_in = fidx_ff + FCW'(1);
               if (ft_rd_len >= size_ff && (!found_ff || better ||
                                            fit_mode_ff == FIT_FIRST)) begin
                  found_in      = 1'b1;
                  chosen_in     = fidx_ff[FIW-1:0];
                  best_len_in   = ft_rd_len;
                  best_start_in = ft_rd_start;
                  if (fit_mode_ff == FIT_FIRST) state_in = S_ACOMMIT;
               end
            end
         end
         S_ACOMMIT: begin
            g_wr          = 1'b1;
            gv_in[slot_ff] = 1'b1;
            total_in      = total_ff - size_ff;
            next_id_in    = next_id_ff + ID_BITS'(1);
            res_status_in = ST_OK;
            res_start_in  = best_start_ff;
            res_size_in   = size_ff;
            res_id_in     = next_id_ff;
            if (best_len_ff == size_ff) begin
               ft_ctl.op = SH_REMOVE;
               ft_sh_idx = chosen_ff;
            end else begin
               ft_ctl.wr_en = 1'b1;
               ft_wr_idx    = chosen_ff;
               ft_wr_start  = best_start_ff + AW'(size_ff);
               ft_wr_len    = best_len_ff - size_ff;
            end
            state_in = S_DONE;
         end
         S_PSCAN: begin
            // best_start and best_len hold the released extent here
            if (fidx_ff >= ft_count || ft_rd_start > best_start_ff) begin
               pos_in      = fidx_ff;
               jprev_in    = fidx_ff != '0 && prev_end_ff == EW'(best_start_ff);
               jnext_in    = fidx_ff < ft_count &&
                             EW'(best_start_ff) + EW'(best_len_ff) == EW'(ft_rd_start);
               next_len_in = ft_rd_len;
               state_in    = S_FCOMMIT;
            end else begin
               prev_end_in = EW'(ft_rd_start) + EW'(ft_rd_len);
               prev_len_in = ft_rd_len;
               fidx_in     = fidx_ff + FCW'(1);
            end
         end
         S_FCOMMIT: begin
            res_status_in = ST_OK;
            res_start_in  = best_start_ff;
            res_size_in   = best_len_ff;
            res_id_in     = tid_ff;
            ft_wr_idx     = pos_ff[FIW-1:0] - FIW'(1);
            ft_sh_idx     = pos_ff[FIW-1:0];
            ft_wr_start   = best_start_ff;
            if (jprev_ff && jnext_ff) begin
               ft_ctl.wr_en = 1'b1;
               ft_ctl.op    = SH_REMOVE;
               ft_wr_start  = AW'(prev_end_ff - EW'(prev_len_ff));
               ft_wr_len    = prev_len_ff + best_len_ff + next_len_ff;
            end else if (jprev_ff) begin
               ft_ctl.wr_en = 1'b1;
               ft_wr_start  = AW'(prev_end_ff - EW'(prev_len_ff));
               ft_wr_len    = prev_len_ff + best_len_ff;
            end else if (jnext_ff) begin
               ft_ctl.wr_en = 1'b1;
               ft_wr_idx    = pos_ff[FIW-1:0];
               ft_wr_len    = next_len_ff + best_len_ff;
            end else if (ft_count >= FCW'(FREE_ENTRIES)) begin
               res_status_in = ST_FULL;
            end else begin
               ft_ctl.wr_en = 1'b1;
               ft_ctl.op    = SH_INSERT;
               ft_wr_idx    = pos_ff[FIW-1:0];
               ft_wr_len    = best_len_ff;
            end
            if (jprev_ff || jnext_ff || ft_count < FCW'(FREE_ENTRIES)) begin
               total_in       = total_ff + best_len_ff;
               gv_in[slot_ff] = 1'b0;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               if (res_status_ff == ST_OK) begin
                  rsp_start_in = res_start_ff;
                  rsp_size_in  = res_size_ff;
                  rsp_id_in    = res_id_ff;
               end else begin
                  rsp_start_in = '0;
                  rsp_size_in  = '0;
                  rsp_id_in    = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register writes arrive only while idle
      if (csr_take) begin
         if (csr_chan.index == CSR_FIT_MODE) begin
            fit_mode_in = csr_chan.data[1:0];
         end else if (csr_chan.index == CSR_MEM_SIZE) begin
            mem_size_in = csr_chan.data;
            total_in    = LW'(csr_chan.data);
            next_id_in  = ID_BITS'(1);
            for (int k = 0; k < GRANT_ENTRIES; k++) gv_in[k] = 1'b0;
            ft_ctl = '{op: SH_INIT, wr_en: 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fit_mode_ff  <= FIT_BEST;
         mem_size_ff  <= AW'(DEFAULT_MEMORY);
         total_ff     <= LW'(DEFAULT_MEMORY);
         next_id_ff   <= ID_BITS'(1);
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < GRANT_ENTRIES; k++) gv_ff[k] <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fit_mode_ff  <= fit_mode_in;
         mem_size_ff  <= mem_size_in;
         total_ff     <= total_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < GRANT_ENTRIES; k++) gv_ff[k] <= gv_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (g_wr) begin
         gid_ff[slot_ff] <= next_id_ff;
         gs_ff[slot_ff]  <= best_start_ff;
         gl_ff[slot_ff]  <= size_ff;
      end
      act_ff        <= act_in;
      size_ff       <= size_in;
      tid_ff        <= tid_in;
      gidx_ff       <= gidx_in;
      slot_ff       <= slot_in;
      pow_ff        <= pow_in;
      fidx_ff       <= fidx_in;
      found_ff      <= found_in;
      chosen_ff     <= chosen_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
      prev_end_ff   <= prev_end_in;
      prev_len_ff   <= prev_len_in;
      next_len_ff   <= next_len_in;
      pos_ff        <= pos_in;
      jprev_ff      <= jprev_in;
      jnext_ff      <= jnext_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_size_ff   <= res_size_in;
      res_id_ff     <= res_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_id_ff     <= rsp_id_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.extent_addr  = rsp_start_ff;
   assign rsp_chan.granted_size = rsp_size_ff;
   assign rsp_chan.assigned_id  = rsp_id_ff;

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != S_IDLE)
      else $error("sequencer idle after taking a word");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      ft_count <= FCW'(FREE_ENTRIES))
      else $error("free extent count beyond table");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= LW'(mem_size_ff))
      else $error("free total above managed size");

   a_ok_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_OK |-> rsp_size_ff != '0)
      else $error("successful word with zero size");

endmodule

@@ sv/fla_free_table.sv @@
// ----------------------------------------------------------------------------
// fla_free_table
// address ordered table of free extents with one read port, one write port
// and a shift for removal and insertion
// ----------------------------------------------------------------------------
module fla_free_table import fla_pkg::*; #(
   parameter int FREE_ENTRIES = 16,
   parameter int ADDR_BITS    = 16,
   localparam int IW = $clog2(FREE_ENTRIES),
   localparam int CW = $clog2(FREE_ENTRIES + 1),
   localparam int LW = ADDR_BITS + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ft_ctl_type           ctl,
   input  logic [IW-1:0]        sh_idx,
   input  logic [IW-1:0]        wr_idx,
   input  logic [ADDR_BITS-1:0] wr_start,
   input  logic [LW-1:0]        wr_len,
   input  logic [ADDR_BITS-1:0] init_len,
   input  logic [IW-1:0]        rd_idx,
   output logic [ADDR_BITS-1:0] rd_start,
   output logic [LW-1:0]        rd_len,
   output logic [CW-1:0]        count
);

   logic [ADDR_BITS-1:0] start_ff [FREE_ENTRIES];
   logic [LW-1:0]        len_ff   [FREE_ENTRIES];
   logic [ADDR_BITS-1:0] start_in [FREE_ENTRIES];
   logic [LW-1:0]        len_in   [FREE_ENTRIES];
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;

   for (genvar k = 0; k < FREE_ENTRIES; k++) begin : g_entry
      always_comb begin
         start_in[k] = start_ff[k];
         len_in[k]   = len_ff[k];
         case (ctl.op)
            SH_REMOVE: begin
               if (k < FREE_ENTRIES - 1) begin
                  if (IW'(k) >= sh_idx) begin
                     start_in[k] = start_ff[(k < FREE_ENTRIES - 1) ? k + 1 : k];
                     len_in[k]   = len_ff[(k < FREE_ENTRIES - 1) ? k + 1 : k];
                  end
               end
            end
            SH_INSERT: begin
               if (k > 0) begin
                  if (IW'(k) > sh_idx) begin
                     start_in[k] = start_ff[(k > 0) ? k - 1 : k];
                     len_in[k]   = len_ff[(k > 0) ? k - 1 : k];
                  end
               end
            end
            SH_INIT: begin
               if (k == 0) begin
                  start_in[k] = '0;
                  len_in[k]   = LW'(init_len);
               end
            end
            default: begin
            end
         endcase
         if (ctl.wr_en && wr_idx == IW'(k)) begin
            start_in[k] = wr_start;
            len_in[k]   = wr_len;
         end
      end
   end

   always_comb begin
      case (ctl.op)
         SH_REMOVE: count_in = count_ff - CW'(1);
         SH_INSERT: count_in = count_ff + CW'(1);
         SH_INIT:   count_in = (init_len != '0) ? CW'(1) : '0;
         default:   count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= CW'(1);
         start_ff[0] <= '0;
         len_ff[0]   <= LW'(DEFAULT_MEMORY);
         for (int k = 1; k < FREE_ENTRIES; k++) begin
            start_ff[k] <= start_in[k];
            len_ff[k]   <= len_in[k];
         end
      end else begin
         count_ff <= count_in;
         for (int k = 0; k < FREE_ENTRIES; k++) begin
            start_ff[k] <= start_in[k];
            len_ff[k]   <= len_in[k];
         end
      end
   end

   assign rd_start = start_ff[rd_idx];
   assign rd_len   = len_ff[rd_idx];
   assign count    = count_ff;

endmodule
